>>> sv/sbcp_pkg.sv
`timescale 1ns / 1ps

package sbcp_pkg;

  // Default width of the backup store address
  localparam int BACKUP_ADDR_BITS_DEF = 16;

  // Input item kinds
  localparam logic [1:0] KIND_XFER = 2'd0;
  localparam logic [1:0] KIND_CS   = 2'd1;
  localparam logic [1:0] KIND_POLL = 2'd2;

  // Command codes in the first command byte
  localparam logic [7:0] CMD_SET_PTR = 8'h01;
  localparam logic [7:0] CMD_WRITE   = 8'h02;
  localparam logic [7:0] CMD_READ    = 8'h03;
  localparam logic [7:0] CMD_STATUS  = 8'h82;
  localparam logic [7:0] CMD_QUIET   = 8'h86;
  localparam logic [7:0] CMD_IRQ     = 8'hFF;

  // Command bytes 0 and 1 both zero select the serial ID query
  localparam logic [7:0] CMD_ID      = 8'h00;

  // Interrupt sub-commands in command bytes 1 and 2
  localparam logic [15:0] IRQ_RAISE  = 16'h0000;
  localparam logic [15:0] IRQ_CLEAR  = 16'h0201;

  // Reply bytes
  localparam logic [7:0] REPLY_BUSY  = 8'hFF;
  localparam logic [7:0] REPLY_ACK   = 8'h01;
  localparam logic [7:0] REPLY_NAK   = 8'h04;
  localparam logic [7:0] STATUS_IRQ  = 8'h02;

  // Checksum polynomial, x^8 term implied
  localparam logic [7:0] CRC_POLY    = 8'h1B;

  // Command byte positions
  localparam logic [7:0] POS_ID_START = 8'd2;
  localparam logic [7:0] POS_CRC     = 8'd3;
  localparam logic [7:0] POS_EXEC    = 8'd4;
  localparam logic [7:0] POS_STATUS  = 8'd6;
  localparam logic [7:0] POS_MAX     = 8'hFF;

  // Poll count limits
  localparam logic [2:0] POLL_MAX    = 3'd7;
  localparam logic [2:0] POLL_DROP   = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data_in;
    logic       chip_select;
  } in_t;

  typedef struct packed {
    logic [7:0] data_out;
    logic       irq_pending;
    logic       checksum_ok;
  } out_t;

  // Fold one byte into the running checksum remainder
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] din);
    logic [7:0] r;
    r = crc ^ din;
    for (int i = 0; i < 8; i++) begin
      r = r[7] ? ((r << 1) ^ CRC_POLY) : (r << 1);
    end
    return r;
  endfunction

  // Serial ID reply sequence
  function automatic logic [7:0] id_byte(input logic [1:0] idx);
    logic [7:0] b;
    case (idx)
      2'd0:    b = 8'h06;
      2'd1:    b = 8'h04;
      2'd2:    b = 8'h10;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

>>> sv/sbcp_ram.sv
`timescale 1ns / 1ps

module sbcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, or read into the output register
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

>>> sv/serial_baseboard_command_port_top.sv
`timescale 1ns / 1ps
//  channel  ports                          word
//  in       in_valid/in_ready/in_data      kind, data_in, chip_select
//  out      out_valid/out_ready/out_data   data_out, irq_pending, checksum_ok
//
//  One word is accepted per cycle while in_ready is high; its result is valid the cycle after.
//  All state updates at the accept edge; a store read for command 03 is
//  issued at that edge and the backup RAM's registered read supplies the
//  reply byte in the result cycle.
//  Reset (rst_n low, synchronous) clears position, command bytes, pointer
//  and interrupt state; the backup store is not cleared.
//  in_ready stays high while the result register is empty or being taken.

module serial_baseboard_command_port_top import sbcp_pkg::*; #(
  parameter int BACKUP_ADDR_BITS = BACKUP_ADDR_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int AW = BACKUP_ADDR_BITS;

  logic          acc;
  logic [7:0]    pos_r, pos_nxt;
  logic [7:0]    cmd0_r, cmd0_nxt;
  logic [7:0]    cmd1_r, cmd1_nxt;
  logic [7:0]    cmd2_r, cmd2_nxt;
  logic [7:0]    crc_r, crc_nxt;
  logic [AW-1:0] ptr_r, ptr_nxt;
  logic          irq_active_r, irq_active_nxt;
  logic [2:0]    poll_cnt_r, poll_cnt_nxt;
  logic [7:0]    irq_status_r, irq_status_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    dout_r, dout_nxt;
  logic          pend_r, pend_nxt;
  logic          ok_r, ok_nxt;
  logic          use_mem_r, use_mem_nxt;
  logic          ram_we, ram_re;
  logic [7:0]    ram_rdata;
  logic [15:0]   ptr_load;
  logic [1:0]    id_idx;
  logic [2:0]    poll_inc;

  assign in_ready = !out_valid_r || out_ready;
  assign acc      = in_valid && in_ready;
  assign ptr_load = {cmd1_r, cmd2_r};
  assign id_idx   = pos_r[1:0] - 2'd2;
  assign poll_inc = (poll_cnt_r == POLL_MAX) ? POLL_MAX : poll_cnt_r + 3'd1;

  // Backup store, read and written at the pointer
  sbcp_ram #(
    .WIDTH(8),
    .DEPTH(1 << AW)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (ram_re),
    .addr (ptr_r),
    .wdata(cmd1_r),
    .rdata(ram_rdata)
  );

  // Decode the accepted word and update state
  always_comb begin
    pos_nxt        = pos_r;
    cmd0_nxt       = cmd0_r;
    cmd1_nxt       = cmd1_r;
    cmd2_nxt       = cmd2_r;
    crc_nxt        = crc_r;
    ptr_nxt        = ptr_r;
    irq_active_nxt = irq_active_r;
    poll_cnt_nxt   = poll_cnt_r;
    irq_status_nxt = irq_status_r;
    dout_nxt       = 8'h00;
    pend_nxt       = 1'b0;
    ok_nxt         = 1'b0;
    use_mem_nxt    = 1'b0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    if (acc) begin
      case (in_data.kind)
        KIND_XFER: begin
          // Capture command bytes and fold them into the checksum
          case (pos_r)
            8'd0: begin
              cmd0_nxt = in_data.data_in;
              crc_nxt  = crc8_step(8'h00, in_data.data_in);
            end
            8'd1: begin
              cmd1_nxt = in_data.data_in;
              crc_nxt  = crc8_step(crc_r, in_data.data_in);
            end
            8'd2: begin
              cmd2_nxt = in_data.data_in;
              crc_nxt  = crc8_step(crc_r, in_data.data_in);
            end
            default: ;
          endcase
          ok_nxt = (pos_r == POS_CRC) && (in_data.data_in == crc_r);

          // Pick the reply byte
          if (pos_r >= POS_ID_START && cmd0_r == CMD_ID && cmd1_r == CMD_ID) begin
            dout_nxt = id_byte(id_idx);
          end else if (pos_r < POS_EXEC) begin
            dout_nxt = REPLY_BUSY;
          end else if (pos_r == POS_EXEC) begin
            case (cmd0_r)
              CMD_SET_PTR: begin
                ptr_nxt  = ptr_load[AW-1:0];
                dout_nxt = REPLY_ACK;
              end
              CMD_WRITE: begin
                ram_we   = 1'b1;
                ptr_nxt  = ptr_r + AW'(1);
                dout_nxt = REPLY_ACK;
              end
              CMD_READ: begin
                dout_nxt = REPLY_ACK;
              end
              CMD_IRQ: begin
                if ({cmd1_r, cmd2_r} == IRQ_RAISE) begin
                  irq_active_nxt = 1'b1;
                  poll_cnt_nxt   = 3'd0;
                  irq_status_nxt = STATUS_IRQ;
                end
                if ({cmd1_r, cmd2_r} == IRQ_CLEAR) begin
                  irq_status_nxt = 8'h00;
                end
                dout_nxt = REPLY_NAK;
              end
              default: dout_nxt = REPLY_NAK;
            endcase
          end else begin
            case (cmd0_r)
              CMD_READ: begin
                ram_re      = 1'b1;
                use_mem_nxt = 1'b1;
                ptr_nxt     = ptr_r + AW'(1);
              end
              CMD_STATUS: begin
                if (pos_r == POS_STATUS) begin
                  irq_active_nxt = 1'b0;
                  dout_nxt       = irq_status_r;
                end
              end
              CMD_QUIET: dout_nxt = 8'h00;
              default:   dout_nxt = in_data.data_in;
            endcase
          end

          // Advance the position, hold at the top
          if (pos_r != POS_MAX) begin
            pos_nxt = pos_r + 8'd1;
          end
        end
        KIND_CS: begin
          if (in_data.chip_select) begin
            pos_nxt = 8'd0;
          end
        end
        KIND_POLL: begin
          // Report pending, drop it after the fifth poll
          if (irq_active_r) begin
            pend_nxt     = 1'b1;
            poll_cnt_nxt = poll_inc;
            if (poll_inc > POLL_DROP) begin
              irq_active_nxt = 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_nxt = acc ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  // State and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= 8'd0;
      cmd0_r       <= 8'd0;
      cmd1_r       <= 8'd0;
      cmd2_r       <= 8'd0;
      crc_r        <= 8'd0;
      ptr_r        <= '0;
      irq_active_r <= 1'b0;
      poll_cnt_r   <= 3'd0;
      irq_status_r <= 8'd0;
      out_valid_r  <= 1'b0;
    end else begin
      pos_r        <= pos_nxt;
      cmd0_r       <= cmd0_nxt;
      cmd1_r       <= cmd1_nxt;
      cmd2_r       <= cmd2_nxt;
      crc_r        <= crc_nxt;
      ptr_r        <= ptr_nxt;
      irq_active_r <= irq_active_nxt;
      poll_cnt_r   <= poll_cnt_nxt;
      irq_status_r <= irq_status_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Result register, loaded on accept
  always_ff @(posedge clk) begin
    if (acc) begin
      dout_r    <= dout_nxt;
      pend_r    <= pend_nxt;
      ok_r      <= ok_nxt;
      use_mem_r <= use_mem_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_data.data_out    = use_mem_r ? ram_rdata : dout_r;
  assign out_data.irq_pending = pend_r;
  assign out_data.checksum_ok = ok_r;

  // Position holds once it reaches the top
  a_pos_sat: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.kind == KIND_XFER && pos_r == POS_MAX) |=> (pos_r == POS_MAX))
    else $error("byte position left its saturated value");

  // Poll past the drop count clears the interrupt
  a_poll_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_data.kind == KIND_POLL && poll_cnt_r >= POLL_DROP) |=> !irq_active_r)
    else $error("interrupt still active after final poll");

  // A poll result carries no reply byte and no checksum flag
  a_poll_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.irq_pending) |-> (out_data.data_out == 8'h00 && !out_data.checksum_ok))
    else $error("poll result carries transfer fields");

endmodule
